[rtl/core/spq_pkg.sv]
// Shared constants, codes and types for the stable priority queue.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [0:0] {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // broadcast to every cell; at most one is set in a cycle
    typedef struct packed {
        logic ins_en;
        logic shift_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/spq_cell.sv]
// One slot of the sorted chain: holds a pair, compares, takes from a neighbor.
`default_nettype none

module spq_cell (
    input  wire                                   aclk,
    input  spq_pkg::cell_ctl_t                    ctl,
    input  wire logic signed [spq_pkg::DATA_W-1:0] new_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0] new_priority,
    input  wire logic                             occupied,
    input  wire logic                             left_ge,
    input  wire logic signed [spq_pkg::DATA_W-1:0] left_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0] left_priority,
    input  wire logic signed [spq_pkg::DATA_W-1:0] right_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0] right_priority,
    output logic                                  ge,
    output logic signed [spq_pkg::DATA_W-1:0]     entry_value,
    output logic signed [spq_pkg::DATA_W-1:0]     entry_priority
);

    logic signed [spq_pkg::DATA_W-1:0] value_reg, value_next;
    logic signed [spq_pkg::DATA_W-1:0] priority_reg, priority_next;

    // entries ahead of the insert point keep their place (ties stay ahead)
    assign ge = occupied && (priority_reg >= new_priority);

    always_comb begin
        value_next    = value_reg;
        priority_next = priority_reg;
        if (ctl.shift_en) begin
            value_next    = right_value;
            priority_next = right_priority;
        end else if (ctl.ins_en && !ge) begin
            if (left_ge) begin
                value_next    = new_value;
                priority_next = new_priority;
            end else begin
                value_next    = left_value;
                priority_next = left_priority;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign entry_value    = value_reg;
    assign entry_priority = priority_reg;

endmodule

`default_nettype wire

[rtl/core/stable_priority_queue.sv]
// Top level: bounded stable priority queue built as a chain of sorted cells.
//
//  channel | dir | tdata (low bit up)                 | tuser
//  --------+-----+------------------------------------+----------------
//  s_      | in  | item_value[31:0], item_priority    | action
//  m_      | out | out_value[31:0], count[36:32], pad | status
//
// Every cell compares its priority with the new one in parallel; on an insert
// it loads from itself, its left neighbor or the input, on a dequeue from the right.
// An item is taken every cycle while the result register is empty or drained.
// Reset clears the entry count and the result valid; cell contents are left.
// A stalled result holds its item and blocks the input until taken.
`default_nettype none

module stable_priority_queue (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // item_value[31:0], item_priority[63:32]
    input  wire  [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], count[36:32], zero[39:37]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::CNT_W;
    localparam int DW  = spq_pkg::DATA_W;

    logic                 accept;
    logic                 is_deq, full, empty;
    spq_pkg::cell_ctl_t   ctl;
    logic signed [DW-1:0] in_value, in_priority;

    logic [CW-1:0]        count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DW-1:0]        m_value_reg, m_value_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [spq_pkg::COUNT_W-1:0] m_count_reg, m_count_next;
    logic [31:0]          count_wide;

    logic                 ge_w    [CAP];
    logic signed [DW-1:0] val_w   [CAP];
    logic signed [DW-1:0] pri_w   [CAP];

    assign in_value    = s_tdata[31:0];
    assign in_priority = s_tdata[63:32];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser[0] == spq_pkg::ACT_DEQ);
    assign full     = (count_reg == CW'(CAP));
    assign empty    = (count_reg == '0);

    assign ctl.ins_en   = accept && !is_deq && !full;
    assign ctl.shift_en = accept && is_deq && !empty;

    genvar i;
    generate
        for (i = 0; i < CAP; i++) begin : g_cell
            logic                 left_ge;
            logic signed [DW-1:0] left_value, left_priority;
            logic signed [DW-1:0] right_value, right_priority;

            if (i == 0) begin : g_head
                // a virtual entry of top priority sits ahead of the head
                assign left_ge       = 1'b1;
                assign left_value    = '0;
                assign left_priority = '0;
            end else begin : g_mid
                assign left_ge       = ge_w[i-1];
                assign left_value    = val_w[i-1];
                assign left_priority = pri_w[i-1];
            end

            if (i == CAP - 1) begin : g_tail
                assign right_value    = val_w[i];
                assign right_priority = pri_w[i];
            end else begin : g_body
                assign right_value    = val_w[i+1];
                assign right_priority = pri_w[i+1];
            end

            spq_cell u_cell (
                .aclk           (aclk),
                .ctl            (ctl),
                .new_value      (in_value),
                .new_priority   (in_priority),
                .occupied       (CW'(i) < count_reg),
                .left_ge        (left_ge),
                .left_value     (left_value),
                .left_priority  (left_priority),
                .right_value    (right_value),
                .right_priority (right_priority),
                .ge             (ge_w[i]),
                .entry_value    (val_w[i]),
                .entry_priority (pri_w[i])
            );
        end
    endgenerate

    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        if (ctl.ins_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.shift_en) begin
            count_next = count_reg - CW'(1);
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_value_next = ctl.shift_en ? val_w[0] : '0;
            priority if (ctl.ins_en)   m_status_next = spq_pkg::ST_ENQ;
            else if (ctl.shift_en)     m_status_next = spq_pkg::ST_DEQ;
            else if (is_deq)           m_status_next = spq_pkg::ST_EMPTY;
            else                       m_status_next = spq_pkg::ST_FULL;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // count field carries the entry count after the item, which fits in COUNT_W bits
    assign count_wide   = 32'(count_next);
    assign m_count_next = accept ? count_wide[spq_pkg::COUNT_W-1:0] : m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAP))
        else $error("entry count above capacity");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins_en |=> (count_reg == $past(count_reg) + CW'(1)) &&
                       (m_tuser == spq_pkg::ST_ENQ))
        else $error("insert did not grow the count");

    a_deq_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift_en |=> (m_value_reg == $past(val_w[0])) &&
                         (count_reg == $past(count_reg) - CW'(1)))
        else $error("dequeue did not return the head entry");

endmodule

`default_nettype wire
